// File: design/smoc_pkg.sv
// Shared types, constants and the divider step for the occupancy calculator.
// No dependencies; used by sm_occupancy_calculator_unit.
package smoc_pkg;

   // Divider lane widths: dividend/quotient shift word, divisor, partial remainder
   localparam int DivW = 20;

   // Pipeline depths of the divider phases
   localparam int StagesA = 20;  // warps/block, thread, register, shared memory bounds
   localparam int StagesB = 8;   // warp bound, dividend is the 8-bit warp limit
   localparam int StagesE = 17;  // occupancy fraction, 17 quotient bits

   // Configuration register indexes
   localparam logic [2:0] CFG_WARP_WIDTH   = 3'd0;
   localparam logic [2:0] CFG_THREAD_LIMIT = 3'd1;
   localparam logic [2:0] CFG_WARP_LIMIT   = 3'd2;
   localparam logic [2:0] CFG_REG_LIMIT    = 3'd3;
   localparam logic [2:0] CFG_SHARED_LIMIT = 3'd4;
   localparam logic [2:0] CFG_BLOCK_LIMIT  = 3'd5;

   // Reset values
   localparam logic [6:0]  RST_WARP_WIDTH   = 7'd32;
   localparam logic [12:0] RST_THREAD_LIMIT = 13'd2048;
   localparam logic [7:0]  RST_WARP_LIMIT   = 8'd64;
   localparam logic [19:0] RST_REG_LIMIT    = 20'd65536;
   localparam logic [19:0] RST_SHARED_LIMIT = 20'd65536;
   localparam logic [6:0]  RST_BLOCK_LIMIT  = 7'd32;

   // Limiting-factor codes
   localparam logic [2:0] REASON_REGISTERS = 3'd0;
   localparam logic [2:0] REASON_SHARED    = 3'd1;
   localparam logic [2:0] REASON_WARPS     = 3'd2;
   localparam logic [2:0] REASON_THREADS   = 3'd3;
   localparam logic [2:0] REASON_BLOCKS    = 3'd4;

   typedef struct packed {
      logic [11:0] threads_in_block;
      logic [7:0]  regs_per_thread;
      logic [19:0] shared_bytes_per_block;
   } req_type;

   typedef struct packed {
      logic [6:0]  blocks_resident;
      logic [7:0]  warps_resident;
      logic [16:0] occupancy_fraction;
      logic [2:0]  limit_reason;
      logic        bad_request;
   } rsp_type;

   // One restoring divider lane; dq shifts dividend bits out and quotient bits in
   typedef struct packed {
      logic [DivW:0]   rem;
      logic [DivW-1:0] dq;
      logic [DivW-1:0] dvs;
   } lane_type;

   function automatic lane_type div_step(lane_type l);
      lane_type   r;
      logic [DivW:0] sh;
      logic          take;
      sh   = {l.rem[DivW-1:0], l.dq[DivW-1]};
      take = (sh >= {1'b0, l.dvs});
      r.dvs = l.dvs;
      r.rem = take ? (sh - {1'b0, l.dvs}) : sh;
      r.dq  = {l.dq[DivW-2:0], take};
      return r;
   endfunction

   // Bounds above the block limit only need to read as "too large"
   function automatic logic [7:0] sat_bound(logic [DivW-1:0] q);
      return (q > DivW'(127)) ? 8'd128 : q[7:0];
   endfunction

endpackage

// File: design/sm_occupancy_calculator_unit.sv
// Top level of the occupancy calculator: APB register file and divider pipeline.
// Depends on smoc_pkg.
//
// Evaluates one launch shape per clock cycle when the result side keeps up. Each
// request passes a 47-stage pipeline: 20 stages of bit-serial restoring division
// for warps per block and the thread, register and shared memory bounds, 8 stages
// for the warp bound, one stage for the minimum and limiting factor, one for the
// resident-warp product and 17 stages for the occupancy fraction. All stages
// advance together, so a stalled result holds the whole pipeline. Configuration
// must only be written while no request is in flight.
module sm_occupancy_calculator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  smoc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output smoc_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int SA = smoc_pkg::StagesA;
   localparam int SB = smoc_pkg::StagesB;
   localparam int SE = smoc_pkg::StagesE;
   localparam int NS = SA + SB + 2 + SE;
   localparam int W  = smoc_pkg::DivW;

   typedef struct packed {
      smoc_pkg::lane_type wpb;
      smoc_pkg::lane_type thr;
      smoc_pkg::lane_type rgs;
      smoc_pkg::lane_type shm;
      logic bad;
      logic reg_nz;
      logic shm_nz;
   } a_ctx_type;

   typedef struct packed {
      smoc_pkg::lane_type wrp;
      logic [11:0] wpb;
      logic [7:0]  thr;
      logic [7:0]  rgs;
      logic [7:0]  shm;
      logic bad;
      logic reg_nz;
      logic shm_nz;
   } b_ctx_type;

   typedef struct packed {
      logic [6:0]  blocks;
      logic [11:0] wpb;
      logic [2:0]  reason;
      logic        bad;
   } c_ctx_type;

   typedef struct packed {
      smoc_pkg::lane_type occ;
      logic [6:0] blocks;
      logic [7:0] warps;
      logic [2:0] reason;
      logic       bad;
   } e_ctx_type;

   // ---------------- configuration registers ----------------
   logic [6:0]  warp_width_ff;
   logic [12:0] thread_limit_ff;
   logic [7:0]  warp_limit_ff;
   logic [19:0] reg_limit_ff;
   logic [19:0] shared_limit_ff;
   logic [6:0]  block_limit_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         warp_width_ff   <= smoc_pkg::RST_WARP_WIDTH;
         thread_limit_ff <= smoc_pkg::RST_THREAD_LIMIT;
         warp_limit_ff   <= smoc_pkg::RST_WARP_LIMIT;
         reg_limit_ff    <= smoc_pkg::RST_REG_LIMIT;
         shared_limit_ff <= smoc_pkg::RST_SHARED_LIMIT;
         block_limit_ff  <= smoc_pkg::RST_BLOCK_LIMIT;
      end else if (csr_wr) begin
         unique case (csr_idx)
            smoc_pkg::CFG_WARP_WIDTH:   warp_width_ff   <= csr_pwdata[6:0];
            smoc_pkg::CFG_THREAD_LIMIT: thread_limit_ff <= csr_pwdata[12:0];
            smoc_pkg::CFG_WARP_LIMIT:   warp_limit_ff   <= csr_pwdata[7:0];
            smoc_pkg::CFG_REG_LIMIT:    reg_limit_ff    <= csr_pwdata[19:0];
            smoc_pkg::CFG_SHARED_LIMIT: shared_limit_ff <= csr_pwdata[19:0];
            smoc_pkg::CFG_BLOCK_LIMIT:  block_limit_ff  <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         smoc_pkg::CFG_WARP_WIDTH:   csr_prdata = {25'd0, warp_width_ff};
         smoc_pkg::CFG_THREAD_LIMIT: csr_prdata = {19'd0, thread_limit_ff};
         smoc_pkg::CFG_WARP_LIMIT:   csr_prdata = {24'd0, warp_limit_ff};
         smoc_pkg::CFG_REG_LIMIT:    csr_prdata = {12'd0, reg_limit_ff};
         smoc_pkg::CFG_SHARED_LIMIT: csr_prdata = {12'd0, shared_limit_ff};
         smoc_pkg::CFG_BLOCK_LIMIT:  csr_prdata = {25'd0, block_limit_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic          adv;
   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;

   assign adv       = rsp_ready | ~v_ff[NS-1];
   assign req_ready = adv;
   assign rsp_valid = v_ff[NS-1];
   assign v_in      = {v_ff[NS-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // ---------------- phase A: four parallel dividers ----------------
   a_ctx_type a_ff [SA];
   a_ctx_type a_in [SA];
   a_ctx_type a_init;
   logic [19:0] regs_blk;

   always_comb begin
      regs_blk = 20'(req_data.threads_in_block * req_data.regs_per_thread);
      a_init.bad    = (req_data.threads_in_block == 12'd0) | (warp_width_ff == 7'd0);
      a_init.reg_nz = (regs_blk != 20'd0);
      a_init.shm_nz = (req_data.shared_bytes_per_block != 20'd0);
      a_init.wpb.rem = '0;
      a_init.wpb.dq  = W'({1'b0, req_data.threads_in_block} + {6'd0, warp_width_ff} - 13'd1);
      a_init.wpb.dvs = W'(warp_width_ff);
      a_init.thr.rem = '0;
      a_init.thr.dq  = W'(thread_limit_ff);
      a_init.thr.dvs = W'(req_data.threads_in_block);
      a_init.rgs.rem = '0;
      a_init.rgs.dq  = reg_limit_ff;
      a_init.rgs.dvs = regs_blk;
      a_init.shm.rem = '0;
      a_init.shm.dq  = shared_limit_ff;
      a_init.shm.dvs = req_data.shared_bytes_per_block;
      for (int s = 0; s < SA; s++) begin
         a_in[s] = (s == 0) ? a_init : a_ff[(s == 0) ? 0 : s - 1];
         a_in[s].wpb = smoc_pkg::div_step(a_in[s].wpb);
         a_in[s].thr = smoc_pkg::div_step(a_in[s].thr);
         a_in[s].rgs = smoc_pkg::div_step(a_in[s].rgs);
         a_in[s].shm = smoc_pkg::div_step(a_in[s].shm);
      end
   end

   // ---------------- phase B: warp bound ----------------
   b_ctx_type b_ff [SB];
   b_ctx_type b_in [SB];
   b_ctx_type b_init;

   always_comb begin
      b_init.bad    = a_ff[SA-1].bad;
      b_init.reg_nz = a_ff[SA-1].reg_nz;
      b_init.shm_nz = a_ff[SA-1].shm_nz;
      b_init.wpb    = a_ff[SA-1].wpb.dq[11:0];
      b_init.thr    = smoc_pkg::sat_bound(a_ff[SA-1].thr.dq);
      b_init.rgs    = a_ff[SA-1].reg_nz ? smoc_pkg::sat_bound(a_ff[SA-1].rgs.dq)
                                        : {1'b0, block_limit_ff};
      b_init.shm    = a_ff[SA-1].shm_nz ? smoc_pkg::sat_bound(a_ff[SA-1].shm.dq)
                                        : {1'b0, block_limit_ff};
      // dividend left-aligned so eight steps consume it
      b_init.wrp.rem = '0;
      b_init.wrp.dq  = {warp_limit_ff, 12'd0};
      b_init.wrp.dvs = W'(a_ff[SA-1].wpb.dq[11:0]);
      for (int s = 0; s < SB; s++) begin
         b_in[s] = (s == 0) ? b_init : b_ff[(s == 0) ? 0 : s - 1];
         b_in[s].wrp = smoc_pkg::div_step(b_in[s].wrp);
      end
   end

   // ---------------- stage C: minimum and limiting factor ----------------
   c_ctx_type c_ff, c_in;
   logic [7:0] by_warp, m;

   always_comb begin
      by_warp = smoc_pkg::sat_bound(b_ff[SB-1].wrp.dq);
      m = {1'b0, block_limit_ff};
      if (b_ff[SB-1].thr < m) m = b_ff[SB-1].thr;
      if (by_warp < m)        m = by_warp;
      if (b_ff[SB-1].rgs < m) m = b_ff[SB-1].rgs;
      if (b_ff[SB-1].shm < m) m = b_ff[SB-1].shm;
      if (b_ff[SB-1].reg_nz && m == b_ff[SB-1].rgs)      c_in.reason = smoc_pkg::REASON_REGISTERS;
      else if (b_ff[SB-1].shm_nz && m == b_ff[SB-1].shm) c_in.reason = smoc_pkg::REASON_SHARED;
      else if (m == by_warp)                             c_in.reason = smoc_pkg::REASON_WARPS;
      else if (m == b_ff[SB-1].thr)                      c_in.reason = smoc_pkg::REASON_THREADS;
      else                                               c_in.reason = smoc_pkg::REASON_BLOCKS;
      c_in.blocks = m[6:0];
      c_in.wpb    = b_ff[SB-1].wpb;
      c_in.bad    = b_ff[SB-1].bad;
   end

   // ---------------- stage D: resident warps ----------------
   e_ctx_type d_ff, d_in;

   always_comb begin
      d_in.blocks = c_ff.blocks;
      d_in.reason = c_ff.reason;
      d_in.bad    = c_ff.bad;
      d_in.warps  = 8'(c_ff.blocks * c_ff.wpb);
      d_in.occ    = '0;
   end

   // ---------------- phase E: occupancy fraction ----------------
   // quotient stays below 2^17 since warps never exceed the warp limit,
   // so the upper dividend bits preload the remainder
   e_ctx_type e_ff [SE];
   e_ctx_type e_in [SE];
   e_ctx_type e_init;

   always_comb begin
      e_init         = d_ff;
      e_init.occ.rem = (W + 1)'(d_ff.warps[7:1]);
      e_init.occ.dq  = {d_ff.warps[0], 19'd0};
      e_init.occ.dvs = W'(warp_limit_ff);
      for (int s = 0; s < SE; s++) begin
         e_in[s] = (s == 0) ? e_init : e_ff[(s == 0) ? 0 : s - 1];
         e_in[s].occ = smoc_pkg::div_step(e_in[s].occ);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         e_ff <= e_in;
      end
   end

   // ---------------- result ----------------
   always_comb begin
      if (e_ff[SE-1].bad) begin
         rsp_data = '0;
         rsp_data.bad_request = 1'b1;
      end else begin
         rsp_data.blocks_resident    = e_ff[SE-1].blocks;
         rsp_data.warps_resident     = e_ff[SE-1].warps;
         rsp_data.occupancy_fraction = (warp_limit_ff == 8'd0) ? 17'd0
                                                               : e_ff[SE-1].occ.dq[16:0];
         rsp_data.limit_reason       = e_ff[SE-1].reason;
         rsp_data.bad_request        = 1'b0;
      end
   end

endmodule

// File: tb/tb.sv
// Testbench for sm_occupancy_calculator_unit: directed and random launch shapes,
// register writes over APB, scoreboard against an in-bench occupancy predictor.
// Depends on smoc_pkg and the RTL top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   smoc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   smoc_pkg::rsp_type rsp_data;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   sm_occupancy_calculator_unit uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the configuration
   logic [6:0]  warp_width;
   logic [12:0] thread_limit;
   logic [7:0]  warp_limit;
   logic [19:0] reg_limit;
   logic [19:0] shared_limit;
   logic [6:0]  block_limit;

   smoc_pkg::rsp_type occupancy_q[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned recv_hold = 0;
   bit failed = 0;
   longint unsigned cycle_count = 0;

   function automatic smoc_pkg::rsp_type predict_occupancy(smoc_pkg::req_type r);
      smoc_pkg::rsp_type o;
      longint unsigned tib, rpt, shb, wpb, regs_blk, by_thr, by_warp, by_reg, by_shm;
      longint unsigned blocks, warps;
      o = '0;
      tib = r.threads_in_block;
      rpt = r.regs_per_thread;
      shb = r.shared_bytes_per_block;
      if (tib == 0 || warp_width == 0) begin
         o.bad_request = 1'b1;
         return o;
      end
      wpb = (tib + warp_width - 1) / warp_width;
      regs_blk = tib * rpt;
      by_thr = thread_limit / tib;
      by_warp = warp_limit / wpb;
      by_reg = regs_blk > 0 ? reg_limit / regs_blk : block_limit;
      by_shm = shb > 0 ? shared_limit / shb : block_limit;
      blocks = block_limit;
      if (by_thr < blocks) blocks = by_thr;
      if (by_warp < blocks) blocks = by_warp;
      if (by_reg < blocks) blocks = by_reg;
      if (by_shm < blocks) blocks = by_shm;
      if (blocks == by_reg && regs_blk > 0) o.limit_reason = smoc_pkg::REASON_REGISTERS;
      else if (blocks == by_shm && shb > 0) o.limit_reason = smoc_pkg::REASON_SHARED;
      else if (blocks == by_warp) o.limit_reason = smoc_pkg::REASON_WARPS;
      else if (blocks == by_thr) o.limit_reason = smoc_pkg::REASON_THREADS;
      else o.limit_reason = smoc_pkg::REASON_BLOCKS;
      warps = blocks * wpb;
      o.blocks_resident = blocks[6:0];
      o.warps_resident = warps[7:0];
      o.occupancy_fraction = warp_limit > 0 ? 17'((warps << 16) / warp_limit) : '0;
      return o;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 64'd2000000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stalls plus long hold-offs
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_ready <= 1'b0;
      end else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      smoc_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (occupancy_q.size() == 0) begin
            $error("result with no request pending");
            failed = 1;
         end else begin
            e = occupancy_q.pop_front();
            if (rsp_data.blocks_resident !== e.blocks_resident) begin
               $error("blocks_resident exp %0d got %0d", e.blocks_resident,
                      rsp_data.blocks_resident);
               failed = 1;
            end
            if (rsp_data.warps_resident !== e.warps_resident) begin
               $error("warps_resident exp %0d got %0d", e.warps_resident,
                      rsp_data.warps_resident);
               failed = 1;
            end
            if (rsp_data.occupancy_fraction !== e.occupancy_fraction) begin
               $error("occupancy_fraction exp %0d got %0d", e.occupancy_fraction,
                      rsp_data.occupancy_fraction);
               failed = 1;
            end
            if (rsp_data.limit_reason !== e.limit_reason) begin
               $error("limit_reason exp %0d got %0d", e.limit_reason,
                      rsp_data.limit_reason);
               failed = 1;
            end
            if (rsp_data.bad_request !== e.bad_request) begin
               $error("bad_request exp %0d got %0d", e.bad_request,
                      rsp_data.bad_request);
               failed = 1;
            end
         end
      end
   end

   // valid stays up between back-to-back transactions; drain drops it
   task automatic send_launch(input logic [11:0] tib, input logic [7:0] rpt,
                              input logic [19:0] shb);
      smoc_pkg::req_type r;
      r.threads_in_block = tib;
      r.regs_per_thread = rpt;
      r.shared_bytes_per_block = shb;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      occupancy_q.push_back(predict_occupancy(r));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (occupancy_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         smoc_pkg::CFG_WARP_WIDTH:   warp_width = val[6:0];
         smoc_pkg::CFG_THREAD_LIMIT: thread_limit = val[12:0];
         smoc_pkg::CFG_WARP_LIMIT:   warp_limit = val[7:0];
         smoc_pkg::CFG_REG_LIMIT:    reg_limit = val[19:0];
         smoc_pkg::CFG_SHARED_LIMIT: shared_limit = val[19:0];
         smoc_pkg::CFG_BLOCK_LIMIT:  block_limit = val[6:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [6:0] ww, input logic [12:0] tl,
                             input logic [7:0] wl, input logic [19:0] rl,
                             input logic [19:0] sl, input logic [6:0] bl);
      csr_write(smoc_pkg::CFG_WARP_WIDTH, 32'(ww));
      csr_write(smoc_pkg::CFG_THREAD_LIMIT, 32'(tl));
      csr_write(smoc_pkg::CFG_WARP_LIMIT, 32'(wl));
      csr_write(smoc_pkg::CFG_REG_LIMIT, 32'(rl));
      csr_write(smoc_pkg::CFG_SHARED_LIMIT, 32'(sl));
      csr_write(smoc_pkg::CFG_BLOCK_LIMIT, 32'(bl));
   endtask

   task automatic random_launch;
      logic [11:0] tib;
      logic [7:0] rpt;
      logic [19:0] shb;
      case ($urandom_range(9))
         0: tib = 12'($urandom);
         1: tib = 12'($urandom_range(1, 32));
         default: tib = 12'($urandom_range(1, 1024));
      endcase
      rpt = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom);
      case ($urandom_range(5))
         0: shb = 20'd0;
         1: shb = 20'($urandom);
         default: shb = 20'($urandom_range(1, 16384));
      endcase
      send_launch(tib, rpt, shb);
   endtask

   task automatic test_directed;
      send_launch(12'd0, 8'd32, 20'd1024);            // zero block size
      send_launch(12'd4095, 8'd255, 20'hFFFFF);
      send_launch(12'd1, 8'd0, 20'd0);                // no register/memory demand
      send_launch(12'd256, 8'd32, 20'd0);             // register limited
      send_launch(12'd128, 8'd0, 20'd16384);          // shared limited
      send_launch(12'd64, 8'd0, 20'd0);               // block/thread/warp bounds tie
      send_launch(12'd1024, 8'd16, 20'd0);            // threads/warps tie
      send_launch(12'd33, 8'd1, 20'd1);               // partial warp
      send_launch(12'd2048, 8'd255, 20'd65536);
      send_launch(12'd1, 8'd255, 20'd1);
      send_launch(12'd2048, 8'd0, 20'd0);
      send_launch(12'd2049, 8'd1, 20'd1);
      drain();
      set_config(7'd0, 13'd2048, 8'd64, 20'd65536, 20'd65536, 7'd32);  // zero warp width
      send_launch(12'd64, 8'd8, 20'd64);
      drain();
      set_config(7'd1, 13'd8191, 8'd0, 20'hFFFFF, 20'hFFFFF, 7'd127);  // zero warp limit
      send_launch(12'd1, 8'd0, 20'd0);
      send_launch(12'd4095, 8'd255, 20'hFFFFF);
      drain();
      set_config(7'd127, 13'd0, 8'd255, 20'd0, 20'd0, 7'd0);
      send_launch(12'd1, 8'd1, 20'd1);
      send_launch(12'd1, 8'd0, 20'd0);
      drain();
      set_config(7'd64, 13'd4096, 8'd128, 20'hFFFFF, 20'hFFFFF, 7'd64);
      send_launch(12'd1, 8'd1, 20'd1);
      send_launch(12'd64, 8'd0, 20'd0);
      send_launch(12'd4095, 8'd1, 20'd1);
      drain();
   endtask

   task automatic test_random_configs(input int n_phases, input int per_phase);
      for (int p = 0; p < n_phases; p++) begin
         if ($urandom_range(3) == 0)
            set_config(7'($urandom), 13'($urandom), 8'($urandom), 20'($urandom),
                       20'($urandom), 7'($urandom));
         else
            set_config(7'($urandom_range(1, 64)), 13'($urandom_range(0, 4096)),
                       8'($urandom_range(0, 128)), 20'($urandom),
                       20'($urandom), 7'($urandom_range(0, 64)));
         for (int i = 0; i < per_phase; i++) random_launch();
         drain();
      end
   endtask

   task automatic test_backpressure;
      set_config(7'd32, 13'd2048, 8'd64, 20'd65536, 20'd65536, 7'd32);
      send_idle_pct = 0;
      recv_hold = 300;
      for (int i = 0; i < 120; i++) random_launch();
      drain();
   endtask

   initial begin
      warp_width = smoc_pkg::RST_WARP_WIDTH;
      thread_limit = smoc_pkg::RST_THREAD_LIMIT;
      warp_limit = smoc_pkg::RST_WARP_LIMIT;
      reg_limit = smoc_pkg::RST_REG_LIMIT;
      shared_limit = smoc_pkg::RST_SHARED_LIMIT;
      block_limit = smoc_pkg::RST_BLOCK_LIMIT;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 37;
      recv_idle_pct = 74;
      test_directed();
      test_random_configs(5, 50);
      send_idle_pct = 74;
      recv_idle_pct = 37;
      test_random_configs(5, 50);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_configs(6, 50);
      test_backpressure();
      if (!failed) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

// File: files.f
design/smoc_pkg.sv
design/sm_occupancy_calculator_unit.sv
tb/tb.sv
